// ===== rtl/core/mrc_pkg.sv =====
// shared types, codes and the byte-wide crc for the modbus rtu response checker
package mrc_pkg;

  // item kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_GAP   = 2'd2;

  // function selects
  localparam logic [1:0] FN_READ_HOLDING  = 2'd0;
  localparam logic [1:0] FN_WRITE_SINGLE  = 2'd1;
  localparam logic [1:0] FN_WRITE_MULTI   = 2'd2;
  localparam logic [1:0] FN_RESERVED      = 2'd3;

  // function codes on the wire
  localparam logic [7:0] CODE_READ_HOLDING = 8'h03;
  localparam logic [7:0] CODE_WRITE_SINGLE = 8'h06;
  localparam logic [7:0] CODE_WRITE_MULTI  = 8'h10;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TIMEOUT   = 3'd1;
  localparam logic [2:0] ST_CRC       = 3'd2;
  localparam logic [2:0] ST_MISMATCH  = 3'd3;
  localparam logic [2:0] ST_BYTECOUNT = 3'd4;
  localparam logic [2:0] ST_LENGTH    = 3'd5;
  localparam logic [2:0] ST_BADCOUNT  = 3'd6;

  // crc-16/modbus
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // frame lengths and thresholds
  localparam logic [7:0] READ_OVERHEAD = 8'd5;
  localparam logic [7:0] WRITE_LENGTH  = 8'd8;
  localparam logic [7:0] GAP_MIN_BYTES = 8'd4;
  localparam logic [7:0] DATA_START    = 8'd3;

  // request item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic [7:0] unit_address;
    logic [1:0] function_select;
    logic [6:0] register_count;
  } req_t;

  // result item
  typedef struct packed {
    logic        is_status;
    logic [6:0]  register_index;
    logic [15:0] register_value;
    logic [2:0]  status;
    logic        last;
  } rsp_t;

  // one request slot between stages
  typedef struct packed {
    logic valid;
    req_t req;
  } req_slot_t;

  // one result slot between stages
  typedef struct packed {
    logic valid;
    rsp_t rsp;
  } rsp_slot_t;

  // one byte through the reflected crc, bit by bit
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // wire code for a function select
  function automatic logic [7:0] fn_code(input logic [1:0] fn);
    logic [7:0] code;
    unique case (fn)
      FN_READ_HOLDING: code = CODE_READ_HOLDING;
      FN_WRITE_SINGLE: code = CODE_WRITE_SINGLE;
      FN_WRITE_MULTI:  code = CODE_WRITE_MULTI;
      default:         code = CODE_READ_HOLDING;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/core/modbus_rtu_response_checker.sv =====
// top level of the modbus rtu response checker
//
//  channel   handshake               payload         direction
//  request   req_valid / req_stall   req   (req_t)   in
//  result    res_valid / res_stall   res   (rsp_t)   out
//
// one request per cycle while req_stall is low; a result passes through the input register,
// then the crc/check logic into the result register
// the byte-wide crc unrolled over eight bit steps sets the critical path
// rst is synchronous and clears the transaction state and both stage valids
// a stalled result holds the engine and backs up into req_stall in the same cycle
module modbus_rtu_response_checker #(
  parameter int MAX_REGISTERS = 125
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  mrc_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_stall,
  output mrc_pkg::rsp_t res
);

  mrc_pkg::req_slot_t slot;
  mrc_pkg::rsp_slot_t result;
  logic               advance;

  // input register
  mrc_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .advance   (advance),
    .slot      (slot)
  );

  // checker engine
  mrc_engine #(
    .MAX_REGISTERS (MAX_REGISTERS)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .slot    (slot),
    .advance (advance),
    .result  (result)
  );

  // result register
  mrc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .result    (result),
    .advance   (advance),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

`ifndef NO_ASSERTIONS
  // requests back up only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> res_valid && res_stall)
    else $error("request stalled without a held result");

  // status results always carry last
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.is_status |-> res.last)
    else $error("status result without last");

  // register results carry no status
  a_reg_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.is_status |-> !res.last && res.status == mrc_pkg::ST_OK)
    else $error("register result with status bits");
`endif

endmodule

// ===== rtl/core/mrc_in_stage.sv =====
// input register stage: captures one request per cycle unless the engine is held
module mrc_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  mrc_pkg::req_t     req,
  input  logic              advance,
  output mrc_pkg::req_slot_t slot
);

  logic          valid;
  mrc_pkg::req_t data;

  // hold while a captured request cannot move on
  assign req_stall = valid && !advance;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!req_stall) begin
      valid <= req_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!req_stall) begin
      data <= req;
    end
  end

  assign slot.valid = valid;
  assign slot.req   = data;

endmodule

// ===== rtl/core/mrc_engine.sv =====
// transaction state, crc update, header and count checks, result forming
module mrc_engine #(
  parameter int MAX_REGISTERS = 125
) (
  input  logic               clk,
  input  logic               rst,
  input  mrc_pkg::req_slot_t slot,
  input  logic               advance,
  output mrc_pkg::rsp_slot_t result
);

  localparam logic [6:0] MaxRegs = 7'(MAX_REGISTERS);

  // transaction state
  logic        busy, busy_next;
  logic [7:0]  exp_addr, exp_addr_next;
  logic [1:0]  exp_fn, exp_fn_next;
  logic [6:0]  exp_count, exp_count_next;
  logic [7:0]  byte_pos, byte_pos_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  high_hold, high_hold_next;
  logic        header_ok, header_ok_next;
  logic        count_ok, count_ok_next;

  logic        proc;
  logic [7:0]  total_len;
  logic [7:0]  count_bytes;
  logic [15:0] crc_upd;
  logic [8:0]  pos_inc;
  logic [8:0]  data_end;
  logic        hdr_upd, cnt_upd;
  logic        in_data;
  logic [7:0]  data_off;
  logic        bad_start;
  mrc_pkg::req_t r;

  // end-of-frame status, checks in priority order
  function automatic logic [2:0] final_status(input logic [7:0] n, input logic [15:0] c,
                                              input logic [1:0] fn, input logic hdr,
                                              input logic cnt, input logic [7:0] tot);
    logic [2:0] st;
    if (c != 16'h0000) begin
      st = mrc_pkg::ST_CRC;
    end else if (fn == mrc_pkg::FN_READ_HOLDING) begin
      if (n < mrc_pkg::READ_OVERHEAD) begin
        st = mrc_pkg::ST_LENGTH;
      end else if (!hdr) begin
        st = mrc_pkg::ST_MISMATCH;
      end else if (!cnt) begin
        st = mrc_pkg::ST_BYTECOUNT;
      end else if (n != tot) begin
        st = mrc_pkg::ST_LENGTH;
      end else begin
        st = mrc_pkg::ST_OK;
      end
    end else if (n < mrc_pkg::WRITE_LENGTH) begin
      st = mrc_pkg::ST_LENGTH;
    end else if (!hdr) begin
      st = mrc_pkg::ST_MISMATCH;
    end else begin
      st = mrc_pkg::ST_OK;
    end
    return st;
  endfunction

  assign r    = slot.req;
  assign proc = slot.valid && advance;

  // expected frame length and data window
  assign count_bytes = {exp_count, 1'b0};
  assign total_len   = (exp_fn == mrc_pkg::FN_READ_HOLDING) ?
                       mrc_pkg::READ_OVERHEAD + count_bytes : mrc_pkg::WRITE_LENGTH;
  assign data_end    = {1'b0, mrc_pkg::DATA_START} + {1'b0, count_bytes};
  assign data_off    = byte_pos - mrc_pkg::DATA_START;
  assign in_data     = (byte_pos >= mrc_pkg::DATA_START) && ({1'b0, byte_pos} < data_end);
  assign pos_inc     = {1'b0, byte_pos} + 9'd1;
  assign crc_upd     = mrc_pkg::crc_byte(crc, r.rx_byte);

  // header and byte count checks for the incoming byte
  always_comb begin
    hdr_upd = header_ok;
    cnt_upd = count_ok;
    if (byte_pos == 8'd0 && r.rx_byte != exp_addr) begin
      hdr_upd = 1'b0;
    end
    if (byte_pos == 8'd1 && r.rx_byte != mrc_pkg::fn_code(exp_fn)) begin
      hdr_upd = 1'b0;
    end
    if (exp_fn == mrc_pkg::FN_READ_HOLDING && byte_pos == 8'd2 && r.rx_byte != count_bytes) begin
      cnt_upd = 1'b0;
    end
  end

  assign bad_start = (r.function_select == mrc_pkg::FN_RESERVED) ||
                     (r.function_select == mrc_pkg::FN_READ_HOLDING &&
                      (r.register_count == 7'd0 || r.register_count > MaxRegs));

  // next state and result
  always_comb begin
    busy_next      = busy;
    exp_addr_next  = exp_addr;
    exp_fn_next    = exp_fn;
    exp_count_next = exp_count;
    byte_pos_next  = byte_pos;
    crc_next       = crc;
    high_hold_next = high_hold;
    header_ok_next = header_ok;
    count_ok_next  = count_ok;
    result         = '0;

    if (proc) begin
      unique case (r.kind)
        mrc_pkg::KIND_START: begin
          exp_addr_next  = bad_start ? 8'd0 : r.unit_address;
          exp_fn_next    = bad_start ? mrc_pkg::FN_READ_HOLDING : r.function_select;
          exp_count_next = (bad_start || r.function_select != mrc_pkg::FN_READ_HOLDING) ?
                           7'd0 : r.register_count;
          busy_next      = !bad_start;
          byte_pos_next  = 8'd0;
          crc_next       = mrc_pkg::CRC_INIT;
          high_hold_next = 8'd0;
          header_ok_next = 1'b1;
          count_ok_next  = 1'b1;
          if (bad_start) begin
            result.valid         = 1'b1;
            result.rsp.is_status = 1'b1;
            result.rsp.status    = mrc_pkg::ST_BADCOUNT;
            result.rsp.last      = 1'b1;
          end
        end
        mrc_pkg::KIND_GAP: begin
          if (busy) begin
            busy_next            = 1'b0;
            result.valid         = 1'b1;
            result.rsp.is_status = 1'b1;
            result.rsp.last      = 1'b1;
            result.rsp.status    = (byte_pos < mrc_pkg::GAP_MIN_BYTES) ? mrc_pkg::ST_TIMEOUT :
                                   final_status(byte_pos, crc, exp_fn, header_ok, count_ok,
                                                total_len);
          end
        end
        mrc_pkg::KIND_BYTE: begin
          if (busy) begin
            crc_next       = crc_upd;
            header_ok_next = hdr_upd;
            count_ok_next  = cnt_upd;
            byte_pos_next  = pos_inc[7:0];
            // register data: even offset holds the high byte, odd offset completes it
            if (exp_fn == mrc_pkg::FN_READ_HOLDING && in_data) begin
              if (!data_off[0]) begin
                high_hold_next = r.rx_byte;
              end else if (hdr_upd && cnt_upd) begin
                result.valid              = 1'b1;
                result.rsp.register_index = data_off[7:1];
                result.rsp.register_value = {high_hold, r.rx_byte};
              end
            end
            // frame complete
            if (pos_inc >= {1'b0, total_len}) begin
              busy_next                 = 1'b0;
              result.valid              = 1'b1;
              result.rsp                = '0;
              result.rsp.is_status      = 1'b1;
              result.rsp.last           = 1'b1;
              result.rsp.status         = final_status(pos_inc[7:0], crc_upd, exp_fn, hdr_upd,
                                                       cnt_upd, total_len);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      exp_addr  <= 8'd0;
      exp_fn    <= mrc_pkg::FN_READ_HOLDING;
      exp_count <= 7'd0;
      byte_pos  <= 8'd0;
      crc       <= mrc_pkg::CRC_INIT;
      high_hold <= 8'd0;
      header_ok <= 1'b1;
      count_ok  <= 1'b1;
    end else begin
      busy      <= busy_next;
      exp_addr  <= exp_addr_next;
      exp_fn    <= exp_fn_next;
      exp_count <= exp_count_next;
      byte_pos  <= byte_pos_next;
      crc       <= crc_next;
      high_hold <= high_hold_next;
      header_ok <= header_ok_next;
      count_ok  <= count_ok_next;
    end
  end

`ifndef NO_ASSERTIONS
  // a register value only comes out of a running read
  a_reg_needs_busy: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.rsp.is_status |-> busy && exp_fn == mrc_pkg::FN_READ_HOLDING)
    else $error("register result outside a running read");

  // a status always closes the transaction
  a_status_idles: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.rsp.is_status |=> !busy)
    else $error("checker still busy after status");

  // a running frame never reaches its full length without ending
  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    busy |-> byte_pos < total_len)
    else $error("byte position past frame length");
`endif

endmodule

// ===== rtl/core/mrc_out_stage.sv =====
// result register stage: holds a result until it is taken
module mrc_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  mrc_pkg::rsp_slot_t result,
  output logic               advance,
  output logic               res_valid,
  input  logic               res_stall,
  output mrc_pkg::rsp_t      res
);

  logic          valid;
  mrc_pkg::rsp_t data;

  // free when empty or being taken
  assign advance = !valid || !res_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= result.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (advance) begin
      data <= result.rsp;
    end
  end

  assign res_valid = valid;
  assign res       = data;

endmodule
